FILE: rtl/bmi2_bit_manipulation_unit_macros.svh
// ---------------------------------------------------------------------------
// BMI2 bit manipulation unit: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef BMI2_BIT_MANIPULATION_UNIT_MACROS_SVH
`define BMI2_BIT_MANIPULATION_UNIT_MACROS_SVH

// A condition that holds on every clock edge out of reset.
`define BMI2_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define BMI2_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define BMI2_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bmi2bmu_pkg.sv
// ---------------------------------------------------------------------------
// BMI2 bit manipulation unit: package
// Operation codes and the structures passed between the unit's modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmi2bmu_pkg;

    // Operand width of the datapath.
    localparam int unsigned DataWidth  = 64;
    localparam int unsigned HalfWidth  = 32;
    localparam int unsigned ShiftWidth = 6;

    // Operation encoding of the issue word.
    typedef enum logic [2:0] {
        KIND_PDEP  = 3'd0,
        KIND_PEXT  = 3'd1,
        KIND_BZHI  = 3'd2,
        KIND_RORX  = 3'd3,
        KIND_SHLX  = 3'd4,
        KIND_SHRX  = 3'd5,
        KIND_SARX  = 3'd6,
        KIND_UNDEF = 3'd7
    } kind_t;

    // Decoded operation handed to the shifter.
    typedef struct packed {
        kind_t kind;
        logic  wide;
    } op_t;

    // Shifter output: the value and the BZHI out-of-range indication.
    typedef struct packed {
        logic [DataWidth-1:0] value;
        logic                 bzhi_carry;
    } shift_out_t;

endpackage

FILE: rtl/bmi2bmu_if.sv
// ---------------------------------------------------------------------------
// BMI2 bit manipulation unit: channel interfaces
// Valid/ready channels for the issue word and the completion word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bmi2bmu_issue_if;
    logic                  valid;
    logic                  ready;
    bmi2bmu_pkg::kind_t    kind;
    logic                  wide;
    logic                  vector_long;
    logic [63:0]           reg_operand;
    logic [63:0]           rm_operand;
    logic [7:0]            rotate_count;

    modport source (
        output valid, kind, wide, vector_long, reg_operand, rm_operand, rotate_count,
        input  ready
    );
    modport sink (
        input  valid, kind, wide, vector_long, reg_operand, rm_operand, rotate_count,
        output ready
    );
endinterface

interface bmi2bmu_complete_if;
    logic        valid;
    logic        ready;
    logic [63:0] result;
    logic        flags_update;
    logic        zero_flag;
    logic        carry_flag;
    logic        sign_flag;
    logic        overflow_flag;
    logic        illegal;

    modport source (
        output valid, result, flags_update, zero_flag, carry_flag, sign_flag,
               overflow_flag, illegal,
        input  ready
    );
    modport sink (
        input  valid, result, flags_update, zero_flag, carry_flag, sign_flag,
               overflow_flag, illegal,
        output ready
    );
endinterface

FILE: rtl/bmi2bmu_scatter_gather.sv
// ---------------------------------------------------------------------------
// BMI2 bit manipulation unit: scatter/gather network
// PDEP and PEXT built on a parallel prefix count of the mask bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmi2bmu_scatter_gather (
    input  logic [bmi2bmu_pkg::DataWidth-1:0] src,
    input  logic [bmi2bmu_pkg::DataWidth-1:0] mask,
    output logic [bmi2bmu_pkg::DataWidth-1:0] deposit,
    output logic [bmi2bmu_pkg::DataWidth-1:0] extract
);

    localparam int unsigned W  = bmi2bmu_pkg::DataWidth;
    localparam int unsigned SW = bmi2bmu_pkg::ShiftWidth;

    // Prefix count levels; level 0 holds each bit's lower neighbour of the mask.
    logic [SW:0]   pc [0:SW][W];
    logic [SW-1:0] rank [W];

    // Kogge-Stone prefix sum: rank[k] is the number of mask bits below bit k.
    always_comb
    begin
        for (int k = 0; k < W; k++)
        begin
            if (k == 0)
                pc[0][k] = '0;
            else
                pc[0][k] = {{SW{1'b0}}, mask[k-1]};
        end
        for (int l = 0; l < SW; l++)
        begin
            for (int k = 0; k < W; k++)
            begin
                if (k >= (1 << l))
                    pc[l+1][k] = pc[l][k] + pc[l][k - (1 << l)];
                else
                    pc[l+1][k] = pc[l][k];
            end
        end
        for (int k = 0; k < W; k++)
            rank[k] = pc[SW][k][SW-1:0];
    end

    // Deposit: each set mask bit takes the source bit of its rank.
    always_comb
    begin
        for (int k = 0; k < W; k++)
            deposit[k] = mask[k] & src[rank[k]];
    end

    // Extract: result bit j collects the masked source bit whose rank is j.
    always_comb
    begin
        for (int j = 0; j < W; j++)
        begin
            extract[j] = 1'b0;
            for (int k = 0; k < W; k++)
                extract[j] = extract[j] |
                             (mask[k] & src[k] & (rank[k] == SW'(j)));
        end
    end

endmodule

FILE: rtl/bmi2bmu_shifter.sv
// ---------------------------------------------------------------------------
// BMI2 bit manipulation unit: shifter
// BZHI, RORX, SHLX, SHRX and SARX on operands already cut to width.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmi2bmu_shifter (
    input  bmi2bmu_pkg::op_t                  op,
    input  logic [bmi2bmu_pkg::DataWidth-1:0] src,
    input  logic [bmi2bmu_pkg::DataWidth-1:0] rm,
    input  logic [7:0]                        rotate_count,
    output bmi2bmu_pkg::shift_out_t           out
);

    localparam int unsigned W  = bmi2bmu_pkg::DataWidth;
    localparam int unsigned H  = bmi2bmu_pkg::HalfWidth;
    localparam int unsigned SW = bmi2bmu_pkg::ShiftWidth;

    logic [SW-1:0]  count;
    logic [SW-1:0]  rot;
    logic [7:0]     index;
    logic           index_over;
    logic [W-1:0]   keep_mask;
    logic [2*W-1:0] rot_wide;
    logic [2*H-1:0] rot_half;
    logic [W-1:0]   rorx_value;
    logic [W-1:0]   shl_value;
    logic [W-1:0]   sar_value;
    logic [H-1:0]   sar_half;

    // Counts masked to the operand width.
    assign count = op.wide ? src[SW-1:0] : {1'b0, src[SW-2:0]};
    assign rot   = op.wide ? rotate_count[SW-1:0] : {1'b0, rotate_count[SW-2:0]};

    // BZHI keeps the bits below the index; an index at or past the width keeps all.
    assign index      = src[7:0];
    assign index_over = op.wide ? (index >= 8'(W)) : (index >= 8'(H));
    assign keep_mask  = (W'(1) << index[SW-1:0]) - W'(1);

    // Rotate by shifting a doubled copy of the operand.
    assign rot_wide   = {rm, rm} >> rot;
    assign rot_half   = {rm[H-1:0], rm[H-1:0]} >> rot[SW-2:0];
    assign rorx_value = op.wide ? rot_wide[W-1:0] : {{(W-H){1'b0}}, rot_half[H-1:0]};

    // Left shift is cut back to the operand width.
    assign shl_value = op.wide ? (rm << count) : {{(W-H){1'b0}}, rm[H-1:0] << count[SW-2:0]};

    // Arithmetic right shift fills from the top bit at the operand width.
    assign sar_half  = H'($signed(rm[H-1:0]) >>> count[SW-2:0]);
    assign sar_value = op.wide ? W'($signed(rm) >>> count) : {{(W-H){1'b0}}, sar_half};

    // Select by operation.
    always_comb
    begin
        out.bzhi_carry = 1'b0;
        case (op.kind)
            bmi2bmu_pkg::KIND_BZHI:
            begin
                out.value      = index_over ? rm : (rm & keep_mask);
                out.bzhi_carry = index_over;
            end
            bmi2bmu_pkg::KIND_RORX: out.value = rorx_value;
            bmi2bmu_pkg::KIND_SHLX: out.value = shl_value;
            bmi2bmu_pkg::KIND_SHRX: out.value = rm >> count;
            bmi2bmu_pkg::KIND_SARX: out.value = sar_value;
            default:                out.value = '0;
        endcase
    end

endmodule

FILE: rtl/bmi2_bit_manipulation_unit.sv
// ---------------------------------------------------------------------------
// BMI2 bit manipulation unit
// Execution unit for PDEP, PEXT, BZHI, RORX, SHLX, SHRX and SARX.
// ---------------------------------------------------------------------------
//
//  Channel    Direction  Word carried
//  ---------  ---------  -----------------------------------------------------
//  issue      sink       kind, wide, vector_long, reg_operand, rm_operand,
//                        rotate_count
//  complete   source     result, flags_update, zero_flag, carry_flag,
//                        sign_flag, overflow_flag, illegal
//
//  One word is taken every cycle while issue.ready is high; it is held in
//  the operand register, makes a single pass through the scatter/gather
//  network and the shifter, and is offered from the result register.
//  Reset empties both stages and drops any words they hold; none is emitted.
//  A stalled completion word holds in the result register while the operand
//  register still takes one more word, so the issue side stalls only when
//  both stages are full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bmi2_bit_manipulation_unit_macros.svh"

module bmi2_bit_manipulation_unit (
    input  logic                clk,
    input  logic                rst_n,
    bmi2bmu_issue_if.sink       issue,
    bmi2bmu_complete_if.source  complete
);

    localparam int unsigned W = bmi2bmu_pkg::DataWidth;
    localparam int unsigned H = bmi2bmu_pkg::HalfWidth;

    // Operand stage.
    logic               op_valid_reg;
    logic               op_valid_next;
    bmi2bmu_pkg::kind_t kind_reg;
    logic               wide_reg;
    logic               vlong_reg;
    logic [W-1:0]       reg_op_reg;
    logic [W-1:0]       rm_op_reg;
    logic [7:0]         rot_reg;

    // Result stage.
    logic               res_valid_reg;
    logic               res_valid_next;
    logic [W-1:0]       result_reg;
    logic [W-1:0]       result_next;
    logic               fupd_reg;
    logic               fupd_next;
    logic               zf_reg;
    logic               zf_next;
    logic               cf_reg;
    logic               cf_next;
    logic               sf_reg;
    logic               sf_next;
    logic               ill_reg;
    logic               ill_next;

    // Handshake.
    logic               issue_take;
    logic               res_free;
    logic               op_advance;

    // Datapath.
    logic [W-1:0]            src;
    logic [W-1:0]            rm;
    logic [W-1:0]            deposit;
    logic [W-1:0]            extract;
    bmi2bmu_pkg::op_t        shift_op;
    bmi2bmu_pkg::shift_out_t shift_out;

    // Flow control between the two stages.
    assign res_free    = !res_valid_reg || complete.ready;
    assign op_advance  = op_valid_reg && res_free;
    assign issue.ready = !op_valid_reg || res_free;
    assign issue_take  = issue.valid && issue.ready;

    assign op_valid_next  = issue_take ? 1'b1 : (op_advance ? 1'b0 : op_valid_reg);
    assign res_valid_next = op_advance ? 1'b1 : (complete.ready ? 1'b0 : res_valid_reg);

    // Valid bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg  <= op_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Operand register.
    always_ff @(posedge clk)
    begin
        if (issue_take)
        begin
            kind_reg   <= issue.kind;
            wide_reg   <= issue.wide;
            vlong_reg  <= issue.vector_long;
            reg_op_reg <= issue.reg_operand;
            rm_op_reg  <= issue.rm_operand;
            rot_reg    <= issue.rotate_count;
        end
    end

    // Operands cut to 32 bits in narrow mode.
    assign src = wide_reg ? reg_op_reg : {{(W-H){1'b0}}, reg_op_reg[H-1:0]};
    assign rm  = wide_reg ? rm_op_reg  : {{(W-H){1'b0}}, rm_op_reg[H-1:0]};

    bmi2bmu_scatter_gather u_scatter_gather (
        .src     (src),
        .mask    (rm),
        .deposit (deposit),
        .extract (extract)
    );

    assign shift_op.kind = kind_reg;
    assign shift_op.wide = wide_reg;

    bmi2bmu_shifter u_shifter (
        .op           (shift_op),
        .src          (src),
        .rm           (rm),
        .rotate_count (rot_reg),
        .out          (shift_out)
    );

    // Decode legality, select the result and form the BZHI flags.
    always_comb
    begin
        ill_next = (kind_reg == bmi2bmu_pkg::KIND_UNDEF) ||
                   (vlong_reg && ((kind_reg == bmi2bmu_pkg::KIND_RORX) ||
                                  (kind_reg == bmi2bmu_pkg::KIND_SHLX) ||
                                  (kind_reg == bmi2bmu_pkg::KIND_SHRX) ||
                                  (kind_reg == bmi2bmu_pkg::KIND_SARX)));
        case (kind_reg)
            bmi2bmu_pkg::KIND_PDEP: result_next = deposit;
            bmi2bmu_pkg::KIND_PEXT: result_next = extract;
            default:                result_next = shift_out.value;
        endcase
        if (ill_next)
            result_next = '0;
        fupd_next = !ill_next && (kind_reg == bmi2bmu_pkg::KIND_BZHI);
        zf_next   = fupd_next && (result_next == '0);
        cf_next   = fupd_next && shift_out.bzhi_carry;
        sf_next   = fupd_next && (wide_reg ? result_next[W-1] : result_next[H-1]);
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (op_advance)
        begin
            result_reg <= result_next;
            fupd_reg   <= fupd_next;
            zf_reg     <= zf_next;
            cf_reg     <= cf_next;
            sf_reg     <= sf_next;
            ill_reg    <= ill_next;
        end
    end

    assign complete.valid         = res_valid_reg;
    assign complete.result        = result_reg;
    assign complete.flags_update  = fupd_reg;
    assign complete.zero_flag     = zf_reg;
    assign complete.carry_flag    = cf_reg;
    assign complete.sign_flag     = sf_reg;
    assign complete.overflow_flag = 1'b0;
    assign complete.illegal       = ill_reg;

    // A faulting word writes nothing.
    `BMI2_ASSERT_IMPLIES(a_illegal_quiet, res_valid_reg && ill_reg,
        (result_reg == '0) && !fupd_reg, "illegal word carries a result or flag update")
    // Flags are only raised on a BZHI update.
    `BMI2_ASSERT_IMPLIES(a_flags_gated, res_valid_reg && !fupd_reg,
        !zf_reg && !cf_reg && !sf_reg, "flag raised without a flag update")
    // With both stages full and the output stalled, issue must stall too.
    `BMI2_ASSERT_IMPLIES(a_full_stall, op_valid_reg && res_valid_reg && !complete.ready,
        !issue.ready, "issue taken while both stages are full")
    // A taken word occupies the operand stage on the next cycle.
    `BMI2_ASSERT_NEXT(a_take_fills, issue_take, op_valid_reg,
        "taken word not held in the operand stage")

endmodule

FILE: dv/bmi2_bit_manipulation_unit_checker.sv
// ---------------------------------------------------------------------------
// BMI2 bit manipulation unit: result checker
// Watches the issue and completion channels, predicts the completion word of
// every issue word taken and compares, field by field, in order of issue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmi2_bit_manipulation_unit_checker (
    input  logic         clk,
    input  logic         rst_n,
    bmi2bmu_issue_if     issue,
    bmi2bmu_complete_if  complete,
    output int           mismatch_count,
    output int           words_pending
);

    localparam logic [63:0] LowHalfMask = 64'h0000_0000_FFFF_FFFF;
    localparam int unsigned MismatchReportLimit = 10;

    typedef struct packed {
        logic [63:0] result;
        logic        flags_update;
        logic        zero_flag;
        logic        carry_flag;
        logic        sign_flag;
        logic        overflow_flag;
        logic        illegal;
    } completion_t;

    completion_t expected_completions [$];

    // Works out the completion word for one issue word.
    function automatic completion_t predict_completion(
        input bmi2bmu_pkg::kind_t kind,
        input logic               wide,
        input logic               vector_long,
        input logic [63:0]        reg_operand,
        input logic [63:0]        rm_operand,
        input logic [7:0]         rotate_count
    );
        completion_t c;
        logic [63:0] width_mask;
        logic [63:0] src;
        logic [63:0] rm;
        logic [63:0] value;
        int unsigned op_bits;
        int unsigned count;
        int unsigned pos;
        c          = '0;
        value      = '0;
        pos        = 0;
        width_mask = wide ? '1 : LowHalfMask;
        op_bits    = wide ? bmi2bmu_pkg::DataWidth : bmi2bmu_pkg::HalfWidth;
        src        = reg_operand & width_mask;
        rm         = rm_operand & width_mask;

        if (kind == bmi2bmu_pkg::KIND_UNDEF
            || (vector_long && (kind == bmi2bmu_pkg::KIND_RORX
                                || kind == bmi2bmu_pkg::KIND_SHLX
                                || kind == bmi2bmu_pkg::KIND_SHRX
                                || kind == bmi2bmu_pkg::KIND_SARX)))
        begin
            c.illegal = 1'b1;
            return c;
        end

        case (kind)
            bmi2bmu_pkg::KIND_PDEP:
            begin
                // Scatter the low source bits into the set mask positions.
                for (int k = 0; k < bmi2bmu_pkg::DataWidth; k++)
                begin
                    if (rm[k])
                    begin
                        value[k] = src[pos];
                        pos++;
                    end
                end
            end
            bmi2bmu_pkg::KIND_PEXT:
            begin
                // Gather the masked source bits into the low end.
                for (int k = 0; k < bmi2bmu_pkg::DataWidth; k++)
                begin
                    if (rm[k])
                    begin
                        value[pos] = src[k];
                        pos++;
                    end
                end
            end
            bmi2bmu_pkg::KIND_BZHI:
            begin
                // Only the low byte of the index counts; at or past the width it sets carry.
                count = 32'(reg_operand[7:0]);
                value = rm;
                if (count < op_bits)
                    value = value & ((64'd1 << count) - 64'd1);
                else
                    c.carry_flag = 1'b1;
                c.flags_update = 1'b1;
                c.zero_flag    = (value == '0);
                c.sign_flag    = value[op_bits-1];
            end
            bmi2bmu_pkg::KIND_RORX:
            begin
                count = 32'(rotate_count) & (op_bits - 1);
                value = rm;
                if (count != 0)
                    value = ((rm >> count) | (rm << (op_bits - count))) & width_mask;
            end
            bmi2bmu_pkg::KIND_SHLX:
            begin
                count = 32'(src[5:0]) & (op_bits - 1);
                value = (rm << count) & width_mask;
            end
            bmi2bmu_pkg::KIND_SHRX:
            begin
                count = 32'(src[5:0]) & (op_bits - 1);
                value = rm >> count;
            end
            default:
            begin
                // Arithmetic shift: the sign is taken at the operand width.
                count = 32'(src[5:0]) & (op_bits - 1);
                if (rm[op_bits-1])
                    value = ~((~rm & width_mask) >> count) & width_mask;
                else
                    value = rm >> count;
            end
        endcase
        c.result = value;
        return c;
    endfunction

    // Record each issue word taken, then check each completion word taken.
    always @(posedge clk or negedge rst_n)
    begin
        completion_t expected_word;
        completion_t actual_word;
        if (!rst_n)
        begin
            expected_completions.delete();
            mismatch_count = 0;
            words_pending  = 0;
        end
        else
        begin
            if (issue.valid && issue.ready)
                expected_completions.push_back(predict_completion(issue.kind, issue.wide,
                    issue.vector_long, issue.reg_operand, issue.rm_operand,
                    issue.rotate_count));

            if (complete.valid && complete.ready)
            begin
                actual_word = '{complete.result, complete.flags_update, complete.zero_flag,
                                complete.carry_flag, complete.sign_flag,
                                complete.overflow_flag, complete.illegal};
                if (expected_completions.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MismatchReportLimit)
                        $display("%0t: completion word with none expected: result %h",
                                 $realtime, actual_word.result);
                end
                else
                begin
                    expected_word = expected_completions.pop_front();
                    if (actual_word.result        !== expected_word.result
                     || actual_word.flags_update  !== expected_word.flags_update
                     || actual_word.zero_flag     !== expected_word.zero_flag
                     || actual_word.carry_flag    !== expected_word.carry_flag
                     || actual_word.sign_flag     !== expected_word.sign_flag
                     || actual_word.overflow_flag !== expected_word.overflow_flag
                     || actual_word.illegal       !== expected_word.illegal)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MismatchReportLimit)
                            $display("%0t: mismatch: expected result %h ",
                                     $realtime, expected_word.result,
                                     "upd/z/c/s/o/ill %b%b%b%b%b%b, ",
                                     expected_word.flags_update, expected_word.zero_flag,
                                     expected_word.carry_flag, expected_word.sign_flag,
                                     expected_word.overflow_flag, expected_word.illegal,
                                     "got result %h ", actual_word.result,
                                     "upd/z/c/s/o/ill %b%b%b%b%b%b",
                                     actual_word.flags_update, actual_word.zero_flag,
                                     actual_word.carry_flag, actual_word.sign_flag,
                                     actual_word.overflow_flag, actual_word.illegal);
                    end
                end
            end
            words_pending = expected_completions.size();
        end
    end

endmodule

FILE: dv/bmi2_bit_manipulation_unit_test.sv
// ---------------------------------------------------------------------------
// BMI2 bit manipulation unit: testbench top
// Drives directed and random issue words with random gaps, stalls the
// completion side at random (twice for a long stretch) and gives the verdict
// from the checker's mismatch count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmi2_bit_manipulation_unit_test;

    localparam int RandomWords  = 2000;
    localparam int CycleLimit   = 400000;
    localparam int DrainCycles  = 10;
    localparam int LongHoldOff  = 150;

    logic clk;
    logic rst_n;
    int   mismatch_count;
    int   words_pending;
    int   sender_gap_max;

    bmi2bmu_issue_if    issue_ch ();
    bmi2bmu_complete_if complete_ch ();

    bmi2_bit_manipulation_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .issue    (issue_ch),
        .complete (complete_ch)
    );

    bmi2_bit_manipulation_unit_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .issue          (issue_ch),
        .complete       (complete_ch),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    // Clock.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Offers one issue word after a random gap and waits until it is taken.
    task automatic send_word(
        input bmi2bmu_pkg::kind_t kind,
        input logic               wide,
        input logic               vector_long,
        input logic [63:0]        reg_operand,
        input logic [63:0]        rm_operand,
        input logic [7:0]         rotate_count
    );
        int gap;
        gap = $urandom_range(0, sender_gap_max);
        repeat (gap)
        begin
            issue_ch.valid <= 1'b0;
            @(negedge clk);
        end
        issue_ch.valid        <= 1'b1;
        issue_ch.kind         <= kind;
        issue_ch.wide         <= wide;
        issue_ch.vector_long  <= vector_long;
        issue_ch.reg_operand  <= reg_operand;
        issue_ch.rm_operand   <= rm_operand;
        issue_ch.rotate_count <= rotate_count;
        do
            @(posedge clk);
        while (!issue_ch.ready);
        @(negedge clk);
    endtask

    // Operand patterns weighted towards the edges of each operation.
    function automatic logic [63:0] random_operand();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return {$urandom, $urandom} | 64'h8000_0000_8000_0000;
            3:       return ({$urandom, $urandom} & ~64'hFF) | 64'($urandom_range(0, 70));
            4:       return {$urandom, $urandom} & {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Completion side: random stalls, with two long hold-offs to fill the unit.
    initial
    begin
        int stall;
        int words_taken;
        int stall_max;
        words_taken       = 0;
        stall_max         = 9;
        complete_ch.ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (words_taken % 64 == 0)
                stall_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
            if (words_taken == 300 || words_taken == 1300)
                stall = LongHoldOff;
            else
                stall = $urandom_range(0, stall_max);
            repeat (stall)
            begin
                complete_ch.ready <= 1'b0;
                @(negedge clk);
            end
            complete_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!complete_ch.valid);
            words_taken++;
            @(negedge clk);
        end
    end

    // Run limit.
    initial
    begin
        repeat (CycleLimit) @(posedge clk);
        $display("bmi2_bit_manipulation_unit test failed");
        $finish;
    end

    // Reset, stimulus and verdict.
    initial
    begin
        bmi2bmu_pkg::kind_t kind;
        logic [63:0]        reg_value;
        logic [63:0]        rm_value;
        sender_gap_max        = 9;
        rst_n                 = 1'b0;
        issue_ch.valid        = 1'b0;
        issue_ch.kind         = bmi2bmu_pkg::KIND_PDEP;
        issue_ch.wide         = 1'b0;
        issue_ch.vector_long  = 1'b0;
        issue_ch.reg_operand  = '0;
        issue_ch.rm_operand   = '0;
        issue_ch.rotate_count = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed words: field extremes, every operation and the corner cases.
        send_word(bmi2bmu_pkg::KIND_PDEP, 1'b1, 1'b0, '1, 64'hAAAA_AAAA_AAAA_AAAA, 8'h00);
        send_word(bmi2bmu_pkg::KIND_PDEP, 1'b1, 1'b1, 64'h1234_5678_9ABC_DEF0, '0, 8'hFF);
        send_word(bmi2bmu_pkg::KIND_PDEP, 1'b0, 1'b0, '1, '1, 8'h00);
        send_word(bmi2bmu_pkg::KIND_PEXT, 1'b1, 1'b0, 64'hF0F0_F0F0_0F0F_0F0F, '1, 8'h00);
        send_word(bmi2bmu_pkg::KIND_PEXT, 1'b0, 1'b1, '1, 64'hFFFF_0000_8000_0001, 8'h00);
        send_word(bmi2bmu_pkg::KIND_BZHI, 1'b1, 1'b0, 64'd0, '1, 8'h00);
        send_word(bmi2bmu_pkg::KIND_BZHI, 1'b0, 1'b0, 64'd31, '1, 8'h00);
        send_word(bmi2bmu_pkg::KIND_BZHI, 1'b0, 1'b0, 64'd32, '1, 8'h00);
        send_word(bmi2bmu_pkg::KIND_BZHI, 1'b1, 1'b0, 64'd63, '1, 8'h00);
        send_word(bmi2bmu_pkg::KIND_BZHI, 1'b1, 1'b1, 64'd64, '1, 8'h00);
        send_word(bmi2bmu_pkg::KIND_BZHI, 1'b1, 1'b0, '1, 64'h8000_0000_0000_0000, 8'h00);
        send_word(bmi2bmu_pkg::KIND_BZHI, 1'b0, 1'b0, 64'hFFFF_FF00_0000_0010,
                  64'hFFFF_0000_0000_0000, 8'h00);
        send_word(bmi2bmu_pkg::KIND_RORX, 1'b1, 1'b0, '0, 64'h8000_0000_0000_0001, 8'h00);
        send_word(bmi2bmu_pkg::KIND_RORX, 1'b1, 1'b0, '0, 64'h8000_0000_0000_0001, 8'hFF);
        send_word(bmi2bmu_pkg::KIND_RORX, 1'b0, 1'b0, '1, 64'hFFFF_FFFF_0000_0001, 8'd200);
        send_word(bmi2bmu_pkg::KIND_SHLX, 1'b1, 1'b0, 64'd63, '1, 8'h00);
        send_word(bmi2bmu_pkg::KIND_SHLX, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFE1, '1, 8'h00);
        send_word(bmi2bmu_pkg::KIND_SHRX, 1'b1, 1'b0, '1, '1, 8'h00);
        send_word(bmi2bmu_pkg::KIND_SHRX, 1'b0, 1'b0, 64'd4, 64'hFFFF_FFFF_8000_0000, 8'h00);
        send_word(bmi2bmu_pkg::KIND_SARX, 1'b1, 1'b0, 64'd60, 64'h8000_0000_0000_0000, 8'h00);
        send_word(bmi2bmu_pkg::KIND_SARX, 1'b0, 1'b0, 64'd31, 64'h0000_0000_8000_0000, 8'h00);
        send_word(bmi2bmu_pkg::KIND_SARX, 1'b0, 1'b0, 64'd3, 64'hFFFF_FFFF_7FFF_FFFF, 8'h00);
        send_word(bmi2bmu_pkg::KIND_UNDEF, 1'b1, 1'b0, '1, '1, 8'hFF);
        send_word(bmi2bmu_pkg::KIND_RORX, 1'b1, 1'b1, '1, '1, 8'd5);
        send_word(bmi2bmu_pkg::KIND_SHLX, 1'b0, 1'b1, 64'd1, '1, 8'h00);

        // Random words, in blocks that each draw either no gaps or random gaps.
        for (int i = 0; i < RandomWords; i++)
        begin
            if (i % 100 == 0)
                sender_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
            kind      = bmi2bmu_pkg::kind_t'($urandom_range(0, 7));
            reg_value = random_operand();
            rm_value  = random_operand();
            send_word(kind, 1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0),
                      reg_value, rm_value, 8'($urandom_range(0, 255)));
        end
        issue_ch.valid <= 1'b0;

        // Drain, then let the pipeline settle.
        while (words_pending != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (mismatch_count == 0 && words_pending == 0)
            $display("bmi2_bit_manipulation_unit test passed");
        else
            $display("bmi2_bit_manipulation_unit test failed");
        $finish;
    end

endmodule
